// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

// ----- sv/ogi_pkg.sv -----
// ----------------------------------------------------------------------------
// ogi_pkg
// Shared types and constants of the obstacle inflation unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ogi_pkg;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_GRID_WIDTH   = 2'd0,
    REG_GRID_HEIGHT  = 2'd1,
    REG_RADIUS_CELLS = 2'd2
  } reg_index_t;

  localparam logic [7:0] INFLATED_COST = 8'd200;

  typedef struct packed {
    logic latch;
    logic clear_marks;
    logic store_cell;
    logic kernel_init;
    logic kernel_rd;
    logic kernel_wr;
    logic kernel_step;
    logic read_rd;
    logic emit_read;
    logic emit_oor;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       in_grid;
    logic       positive;
    logic       row_active;
    logic       row_last;
  } ctrl_status_t;

endpackage

// ----- sv/ogi_ctrl.sv -----
// ----------------------------------------------------------------------------
// ogi_ctrl
// Sequencer that dispatches requests and walks the kernel rows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ogi_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  ogi_pkg::ctrl_status_t status,
  output ogi_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_DISPATCH  = 5'b00010,
    S_ROW_RD    = 5'b00100,
    S_ROW_WR    = 5'b01000,
    S_READ_DATA = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_IDLE;
        case (status.mode)
          ogi_pkg::MODE_CLEAR: begin
            cmd.clear_marks = 1'b1;
          end
          ogi_pkg::MODE_LOAD: begin
            if (status.in_grid) begin
              cmd.store_cell = 1'b1;
              if (status.positive) begin
                cmd.kernel_init = 1'b1;
                state_next      = S_ROW_RD;
              end
            end
          end
          ogi_pkg::MODE_READ: begin
            if (status.in_grid) begin
              cmd.read_rd = 1'b1;
              state_next  = S_READ_DATA;
            end else begin
              cmd.emit_oor = 1'b1;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_ROW_RD: begin
        if (status.row_active) begin
          cmd.kernel_rd = 1'b1;
          state_next    = S_ROW_WR;
        end else if (status.row_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.kernel_step = 1'b1;
        end
      end
      S_ROW_WR: begin
        cmd.kernel_wr = 1'b1;
        if (status.row_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.kernel_step = 1'b1;
          state_next      = S_ROW_RD;
        end
      end
      S_READ_DATA: begin
        cmd.emit_read = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/ogi_datapath.sv -----
// ----------------------------------------------------------------------------
// ogi_datapath
// Configuration, request registers, cell and mark memories, kernel geometry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ogi_datapath #(
  parameter int MAX_COLS   = 256,
  parameter int MAX_ROWS   = 256,
  parameter int MAX_RADIUS = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [8:0]            cfg_data,
  input  logic [1:0]            mode,
  input  logic [7:0]            cell_row,
  input  logic [7:0]            cell_col,
  input  logic signed [7:0]     cell_value,
  input  ogi_pkg::ctrl_cmd_t    cmd,
  output ogi_pkg::ctrl_status_t status,
  output logic                  result_strobe,
  output logic [7:0]            cost,
  output logic                  out_of_range
);

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RAD_W = $clog2(MAX_RADIUS + 1);
  localparam int KW    = RAD_W + 1;
  localparam int M1    = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int M2    = (M1 > 8) ? M1 : 8;
  localparam int CW    = ((M2 > RAD_W) ? M2 : RAD_W) + 2;
  localparam int CELL_DEPTH = 1 << (ROW_W + COL_W);

  logic [8:0] grid_width;
  logic [8:0] grid_height;
  logic [3:0] radius_cells;

  logic [1:0]        req_mode;
  logic [7:0]        req_row;
  logic [7:0]        req_col;
  logic signed [7:0] req_value;
  logic [KW-1:0]     k;

  logic signed [CW-1:0] w_eff, h_eff, row_s, col_s;
  logic signed [CW-1:0] rad_s, half_s, k_s, dr, adr, span0, span, rr, col_lo, col_hi;
  logic [RAD_W-1:0]     rad;
  logic [ROW_W-1:0]     req_row_idx, rr_idx, mark_addr;
  logic [COL_W-1:0]     req_col_idx;
  logic [ROW_W+COL_W-1:0] cell_addr;
  logic [MAX_COLS-1:0]  mask;

  logic [MAX_COLS-1:0] mark_mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_valid;
  logic [MAX_COLS-1:0] mark_q;
  logic [7:0]          cell_mem [CELL_DEPTH];
  logic [7:0]          cell_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= 9'd256;
      grid_height  <= 9'd256;
      radius_cells <= 4'd9;
    end else if (cfg_we) begin
      case (cfg_index)
        ogi_pkg::REG_GRID_WIDTH:   grid_width   <= cfg_data;
        ogi_pkg::REG_GRID_HEIGHT:  grid_height  <= cfg_data;
        ogi_pkg::REG_RADIUS_CELLS: radius_cells <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_mode  <= mode;
      req_row   <= cell_row;
      req_col   <= cell_col;
      req_value <= cell_value;
    end
    if (cmd.kernel_init) begin
      k <= '0;
    end else if (cmd.kernel_step) begin
      k <= k + 1'b1;
    end
  end

  always_comb begin
    w_eff = (int'(grid_width) > MAX_COLS) ? CW'(MAX_COLS) : CW'(grid_width);
    h_eff = (int'(grid_height) > MAX_ROWS) ? CW'(MAX_ROWS) : CW'(grid_height);
    rad   = (int'(radius_cells) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius_cells);
    row_s  = $signed(CW'(req_row));
    col_s  = $signed(CW'(req_col));
    rad_s  = $signed(CW'(rad));
    half_s = rad_s >>> 1;
    k_s    = $signed(CW'(k));
    dr     = k_s - rad_s;
    adr    = dr[CW-1] ? -dr : dr;
    span0  = rad_s + half_s - CW'(1) - adr;
    span   = (span0 > rad_s) ? rad_s : span0;
    rr     = row_s + dr;
    col_lo = col_s - span;
    col_hi = col_s + span;
    for (int c = 0; c < MAX_COLS; c++) begin
      mask[c] = (CW'(c) >= col_lo) && (CW'(c) <= col_hi) && (CW'(c) < w_eff);
    end
  end

  assign req_row_idx = ROW_W'(req_row);
  assign req_col_idx = COL_W'(req_col);
  assign rr_idx      = rr[ROW_W-1:0];
  assign mark_addr   = cmd.read_rd ? req_row_idx : rr_idx;
  assign cell_addr   = {req_row_idx, req_col_idx};

  always_comb begin
    status.mode       = req_mode;
    status.in_grid    = (row_s < h_eff) && (col_s < w_eff);
    status.positive   = !req_value[7] && (req_value != 8'sd0);
    status.row_active = !span[CW-1] && !rr[CW-1] && (rr < h_eff);
    status.row_last   = (k == {rad, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (cmd.kernel_rd || cmd.read_rd) begin
      mark_q <= mark_mem[mark_addr];
    end
    if (cmd.kernel_wr) begin
      mark_mem[rr_idx] <= (row_valid[rr_idx] ? mark_q : '0) | mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_marks) begin
      row_valid <= '0;
    end else if (cmd.kernel_wr) begin
      row_valid[rr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_cell) begin
      cell_mem[cell_addr] <= req_value;
    end
    if (cmd.read_rd) begin
      cell_q <= cell_mem[cell_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.emit_read || cmd.emit_oor;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_read) begin
      cost         <= (row_valid[req_row_idx] && mark_q[req_col_idx]) ?
                      ogi_pkg::INFLATED_COST : cell_q;
      out_of_range <= 1'b0;
    end else if (cmd.emit_oor) begin
      cost         <= 8'd0;
      out_of_range <= 1'b1;
    end
  end

endmodule

// ----- sv/occupancy_grid_obstacle_inflation_unit.sv -----
// ----------------------------------------------------------------------------
// occupancy_grid_obstacle_inflation_unit
// Occupancy grid with a plane of inflation marks around occupied cells.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Signals
//  request   start && !busy          mode, cell_row, cell_col, cell_value
//  result    result_strobe (1 cycle) cost, out_of_range
//  config    cfg_we                  cfg_index, cfg_data
//
// Clear, unused and non-marking load requests and out-of-range reads go from dispatch
// straight back to idle, an in-grid read through a data state; a result is strobed
// in the same cycle that busy falls. A load of a positive value walks the 2R+1
// kernel rows, with a read-modify-write of one mark row word for each row in the grid
// whose span is not empty. Reset is synchronous; marks are cleared at once through
// per-row valid bits. The result side cannot stall; the request side waits while busy is high.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module occupancy_grid_obstacle_inflation_unit #(
  parameter int MAX_COLS   = 256,
  parameter int MAX_ROWS   = 256,
  parameter int MAX_RADIUS = 15
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_data,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        mode,
  input  logic [7:0]        cell_row,
  input  logic [7:0]        cell_col,
  input  logic signed [7:0] cell_value,
  output logic              result_strobe,
  output logic [7:0]        cost,
  output logic              out_of_range
);

  ogi_pkg::ctrl_cmd_t    cmd;
  ogi_pkg::ctrl_status_t status;

  ogi_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  ogi_datapath #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mode          (mode),
    .cell_row      (cell_row),
    .cell_col      (cell_col),
    .cell_value    (cell_value),
    .cmd           (cmd),
    .status        (status),
    .result_strobe (result_strobe),
    .cost          (cost),
    .out_of_range  (out_of_range)
  );

  `ASSERT_NEXT(a_strobe_single, result_strobe, !result_strobe)
  `ASSERT_SAME(a_oor_zero_cost, result_strobe && out_of_range, cost == 8'd0)
  `ASSERT_NEXT(a_accept_busy, start && !busy, busy && !result_strobe)
  `ASSERT_SAME(a_wr_after_rd, cmd.kernel_wr, $past(cmd.kernel_rd))

endmodule

// ----- test/tb_occupancy_grid_obstacle_inflation_unit.sv -----
// ----------------------------------------------------------------------------
// tb_occupancy_grid_obstacle_inflation_unit
// Self-checking bench for the obstacle inflation unit. It keeps its own copy of
// the grid, the mark plane and the registers, so it can predict every read.
// It drives directed requests first, then random phases across grid sizes and
// radii. Reads of cells that were never loaded and are not marked are avoided.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_occupancy_grid_obstacle_inflation_unit;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1500;
  localparam int PHASE_COUNT = 8;
  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT = 2000;
  localparam int GRID_COLS = 256;
  localparam int GRID_ROWS = 256;

  typedef struct packed {
    logic [7:0] cost;
    logic       out_of_range;
  } cost_result_t;

  class inflation_scoreboard;
    logic [7:0]   cell_bytes [GRID_ROWS * GRID_COLS];
    bit           cell_loaded [GRID_ROWS * GRID_COLS];
    int unsigned  mark_epoch [GRID_ROWS * GRID_COLS];
    int unsigned  clear_epoch;
    int unsigned  width_reg;
    int unsigned  height_reg;
    int unsigned  radius_reg;
    cost_result_t expected_costs [$];
    int unsigned  loaded_cells [$];
    int           error_count;

    function new();
      clear_epoch = 1;
      width_reg = 256;
      height_reg = 256;
      radius_reg = 9;
      error_count = 0;
    endfunction

    function int unsigned cols_in_use();
      return (width_reg > GRID_COLS) ? GRID_COLS : width_reg;
    endfunction

    function int unsigned rows_in_use();
      return (height_reg > GRID_ROWS) ? GRID_ROWS : height_reg;
    endfunction

    function bit in_grid(int unsigned row, int unsigned col);
      return row < rows_in_use() && col < cols_in_use();
    endfunction

    function bit is_marked(int unsigned row, int unsigned col);
      return mark_epoch[row * GRID_COLS + col] == clear_epoch;
    endfunction

    function bit readable(int unsigned row, int unsigned col);
      return !in_grid(row, col) || cell_loaded[row * GRID_COLS + col] || is_marked(row, col);
    endfunction

    function int pending();
      return expected_costs.size();
    endfunction

    function bit pick_loaded(inout logic [7:0] row, inout logic [7:0] col);
      int unsigned idx;
      if (loaded_cells.size() == 0) begin
        return 1'b0;
      end
      for (int tries = 0; tries < 8; tries++) begin
        idx = loaded_cells[$urandom_range(0, loaded_cells.size() - 1)];
        row = 8'(idx / GRID_COLS);
        col = 8'(idx % GRID_COLS);
        if (in_grid(row, col)) begin
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void write_register(ogi_pkg::reg_index_t index, logic [8:0] data);
      case (index)
        ogi_pkg::REG_GRID_WIDTH: begin
          width_reg = 32'(data);
        end
        ogi_pkg::REG_GRID_HEIGHT: begin
          height_reg = 32'(data);
        end
        ogi_pkg::REG_RADIUS_CELLS: begin
          radius_reg = 32'(data[3:0]);
        end
        default: begin
        end
      endcase
    endfunction

    function void mark_kernel(int row, int col);
      int r;
      int half;
      int rr;
      int cc;
      r = radius_reg;
      half = r / 2;
      for (int dr = 0; dr <= r; dr++) begin
        for (int dc = 0; dc <= r; dc++) begin
          if (dr + dc <= r + half - 1) begin
            for (int k = 0; k < 4; k++) begin
              rr = k[0] ? row - dr : row + dr;
              cc = k[1] ? col - dc : col + dc;
              if (rr >= 0 && cc >= 0 && rr < int'(rows_in_use()) && cc < int'(cols_in_use())) begin
                mark_epoch[rr * GRID_COLS + cc] = clear_epoch;
              end
            end
          end
        end
      end
    endfunction

    function void note_request(logic [1:0] mode, logic [7:0] row, logic [7:0] col,
                               logic signed [7:0] value);
      int unsigned idx;
      cost_result_t result;
      idx = row * GRID_COLS + col;
      case (mode)
        ogi_pkg::MODE_CLEAR: begin
          clear_epoch++;
        end
        ogi_pkg::MODE_LOAD: begin
          if (in_grid(row, col)) begin
            cell_bytes[idx] = value;
            if (!cell_loaded[idx]) begin
              cell_loaded[idx] = 1'b1;
              loaded_cells = {loaded_cells, idx};
            end
            if (value > 0) begin
              mark_kernel(row, col);
            end
          end
        end
        ogi_pkg::MODE_READ: begin
          if (in_grid(row, col)) begin
            result.cost = is_marked(row, col) ? ogi_pkg::INFLATED_COST : cell_bytes[idx];
            result.out_of_range = 1'b0;
          end else begin
            result.cost = 8'd0;
            result.out_of_range = 1'b1;
          end
          expected_costs = {expected_costs, result};
        end
        default: begin
        end
      endcase
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      error_count++;
    endtask

    task check_result(logic [7:0] cost, logic out_of_range);
      cost_result_t want;
      if (expected_costs.size() == 0) begin
        report_mismatch($sformatf("cost %0d with no read request waiting", cost));
      end else begin
        want = expected_costs.pop_front();
        if (cost !== want.cost) begin
          report_mismatch($sformatf("cost %0d, expected %0d", cost, want.cost));
        end
        if (out_of_range !== want.out_of_range) begin
          report_mismatch($sformatf("out_of_range %0b, expected %0b", out_of_range,
                                    want.out_of_range));
        end
      end
    endtask
  endclass

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = 2'd0;
  logic [8:0]        cfg_data = 9'd0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        mode = 2'd0;
  logic [7:0]        cell_row = 8'd0;
  logic [7:0]        cell_col = 8'd0;
  logic signed [7:0] cell_value = 8'sd0;
  logic              result_strobe;
  logic [7:0]        cost;
  logic              out_of_range;

  inflation_scoreboard grid_model = new();
  int unsigned stall_cycles = 0;
  bit          no_idle = 1'b0;
  logic [7:0]  hot_row = 8'd0;
  logic [7:0]  hot_col = 8'd0;

  occupancy_grid_obstacle_inflation_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .cell_row     (cell_row),
    .cell_col     (cell_col),
    .cell_value   (cell_value),
    .result_strobe(result_strobe),
    .cost         (cost),
    .out_of_range (out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      grid_model.check_result(cost, out_of_range);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("occupancy_grid_obstacle_inflation_unit verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_request(logic [1:0] m, logic [7:0] row, logic [7:0] col,
                              logic signed [7:0] value);
    start <= 1'b1;
    mode <= m;
    cell_row <= row;
    cell_col <= col;
    cell_value <= value;
    do @(posedge clk); while (busy);
    grid_model.note_request(m, row, col, value);
  endtask

  task automatic maybe_pause();
    int unsigned gap;
    if (!no_idle && $urandom_range(0, 99) < 15) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_registers(logic [8:0] width, logic [8:0] height, logic [8:0] radius_data);
    logic [8:0] values [3];
    ogi_pkg::reg_index_t index;
    values[0] = width;
    values[1] = height;
    values[2] = radius_data;
    start <= 1'b0;
    while (grid_model.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < 3; i++) begin
      index = ogi_pkg::reg_index_t'(i);
      cfg_we <= 1'b1;
      cfg_index <= index;
      cfg_data <= values[i];
      @(posedge clk);
      grid_model.write_register(index, values[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic move_hotspot();
    if (grid_model.rows_in_use() > 0 && grid_model.cols_in_use() > 0) begin
      hot_row = 8'($urandom_range(0, grid_model.rows_in_use() - 1));
      hot_col = 8'($urandom_range(0, grid_model.cols_in_use() - 1));
    end else begin
      hot_row = 8'($urandom_range(0, 255));
      hot_col = 8'($urandom_range(0, 255));
    end
  endtask

  task automatic random_request();
    int unsigned pick;
    int unsigned rows;
    int unsigned cols;
    logic [1:0]  m;
    logic [7:0]  r;
    logic [7:0]  c;
    logic signed [7:0] v;
    rows = grid_model.rows_in_use();
    cols = grid_model.cols_in_use();
    if ($urandom_range(0, 99) < 5) begin
      move_hotspot();
    end
    r = 8'($urandom_range(0, 255));
    c = 8'($urandom_range(0, 255));
    v = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      m = ogi_pkg::MODE_CLEAR;
    end else if (pick < 5) begin
      m = MODE_UNUSED;
    end else if (pick < 45) begin
      m = ogi_pkg::MODE_LOAD;
      if ($urandom_range(0, 99) < 80) begin
        r = 8'(hot_row + $urandom_range(0, 40) - 20);
        c = 8'(hot_col + $urandom_range(0, 40) - 20);
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        v = 8'($urandom_range(1, 127));
      end else if (pick < 70) begin
        case ($urandom_range(0, 4))
          0: v = 8'sd127;
          1: v = 8'sd1;
          2: v = -8'sd128;
          3: v = -8'sd1;
          default: v = 8'sd0;
        endcase
      end
    end else begin
      m = ogi_pkg::MODE_READ;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        r = 8'(hot_row + $urandom_range(0, 40) - 20);
        c = 8'(hot_col + $urandom_range(0, 40) - 20);
      end else if (pick < 80) begin
        void'(grid_model.pick_loaded(r, c));
      end
      if (!grid_model.readable(r, c)) begin
        if (!grid_model.pick_loaded(r, c)) begin
          if (rows < GRID_ROWS) begin
            r = 8'(rows);
          end else if (cols < GRID_COLS) begin
            c = 8'(cols);
          end else begin
            m = ogi_pkg::MODE_LOAD;
          end
        end
      end
    end
    send_request(m, r, c, v);
  endtask

  initial begin
    logic [8:0] phase_width [PHASE_COUNT];
    logic [8:0] phase_height [PHASE_COUNT];
    logic [8:0] phase_radius [PHASE_COUNT];
    phase_width  = '{9'd256, 9'd16,  9'd256, 9'd40,  9'd300, 9'd256, 9'd1,   9'd0};
    phase_height = '{9'd256, 9'd16,  9'd256, 9'd200, 9'd511, 9'd1,   9'd256, 9'd0};
    phase_radius = '{9'd9,   9'd15,  9'd15,  9'd3,   9'd1,   9'd0,   9'd2,   9'd0};
    phase_width[7] = 9'($urandom_range(1, 300));
    phase_height[7] = 9'($urandom_range(1, 300));
    phase_radius[7] = 9'($urandom_range(0, 511));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_request(ogi_pkg::MODE_LOAD, 8'd0, 8'd0, 8'sd127);
    send_request(ogi_pkg::MODE_LOAD, 8'd255, 8'd255, 8'sd1);
    send_request(ogi_pkg::MODE_LOAD, 8'd128, 8'd128, -8'sd128);
    send_request(ogi_pkg::MODE_LOAD, 8'd128, 8'd129, 8'sd0);
    send_request(ogi_pkg::MODE_LOAD, 8'd100, 8'd100, -8'sd1);
    send_request(ogi_pkg::MODE_READ, 8'd0, 8'd0, 8'sd0);
    send_request(ogi_pkg::MODE_READ, 8'd5, 8'd7, 8'sd0);
    send_request(ogi_pkg::MODE_READ, 8'd255, 8'd246, 8'sd0);
    send_request(ogi_pkg::MODE_READ, 8'd128, 8'd129, 8'sd0);
    send_request(ogi_pkg::MODE_READ, 8'd100, 8'd100, 8'sd0);
    send_request(MODE_UNUSED, 8'd128, 8'd128, 8'sd5);
    send_request(ogi_pkg::MODE_READ, 8'd128, 8'd128, 8'sd0);
    send_request(ogi_pkg::MODE_LOAD, 8'd128, 8'd128, 8'sd5);
    send_request(ogi_pkg::MODE_READ, 8'd128, 8'd129, 8'sd0);
    send_request(ogi_pkg::MODE_CLEAR, 8'd0, 8'd0, 8'sd0);
    send_request(ogi_pkg::MODE_READ, 8'd128, 8'd129, 8'sd0);
    send_request(ogi_pkg::MODE_READ, 8'd0, 8'd0, 8'sd0);

    write_registers(9'd0, 9'd256, 9'd15);
    send_request(ogi_pkg::MODE_LOAD, 8'd0, 8'd0, 8'sd1);
    send_request(ogi_pkg::MODE_READ, 8'd0, 8'd0, 8'sd0);

    write_registers(9'd300, 9'd511, 9'h1FF);
    send_request(ogi_pkg::MODE_READ, 8'd255, 8'd255, 8'sd0);
    send_request(ogi_pkg::MODE_LOAD, 8'd255, 8'd0, 8'sd127);
    send_request(ogi_pkg::MODE_READ, 8'd240, 8'd0, 8'sd0);

    write_registers(9'd1, 9'd1, 9'd0);
    send_request(ogi_pkg::MODE_LOAD, 8'd0, 8'd0, 8'sd127);
    send_request(ogi_pkg::MODE_READ, 8'd0, 8'd0, 8'sd0);
    send_request(ogi_pkg::MODE_READ, 8'd0, 8'd1, 8'sd0);

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      write_registers(phase_width[phase], phase_height[phase], phase_radius[phase]);
      move_hotspot();
      no_idle = (phase == 2);
      repeat (ITEM_TARGET / PHASE_COUNT) begin
        random_request();
        maybe_pause();
      end
    end

    start <= 1'b0;
    while (grid_model.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (grid_model.error_count == 0) begin
      $display("occupancy_grid_obstacle_inflation_unit verification clean");
    end else begin
      $display("occupancy_grid_obstacle_inflation_unit verification failed");
    end
    $finish;
  end

endmodule
